>>> rtl/m4vt_pkg.sv
// Package for the 4x4 float32 matrix-vector block.
// Holds widths, register indexes and the IEEE binary32 helper functions.
package m4vt_pkg;

    localparam int FW = 32;
    localparam int CW = 64;
    localparam int NREG = 8;
    localparam int IW = 3;
    localparam logic [31:0] QNAN = 32'h7FC00000;
    localparam logic [31:0] INF = 32'h7F800000;

    typedef logic [31:0] f32_t;

    typedef struct packed {
        logic       special;
        logic [31:0] sbits;
        logic        sign;
        logic signed [10:0] exp;
        logic [49:0] sig;
    } rnd_t;

    function automatic logic is_nan(input f32_t a);
        return a[30:0] > INF[30:0];
    endfunction

    function automatic logic is_inf(input f32_t a);
        return a[30:0] == INF[30:0];
    endfunction

    function automatic logic is_zero(input f32_t a);
        return a[30:0] == 31'd0;
    endfunction

    // Value = sig * 2^exp; sig below 2^50.
    function automatic f32_t round_pack(input logic sign, input logic signed [10:0] exp,
                                        input logic [49:0] sig);
        logic [5:0] p;
        logic signed [11:0] s;
        logic [49:0] mant;
        logic [49:0] rem;
        logic [49:0] half;
        logic signed [12:0] e;
        logic [33:0] bits;
        p = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (sig[i]) begin
                p = 6'(i);
            end
        end
        s = 12'(signed'({1'b0, p})) - 12'sd23;
        if (s < -12'sd149 - 12'(exp)) begin
            s = -12'sd149 - 12'(exp);
        end
        if (s <= 0) begin
            mant = sig << 6'(-s);
        end else if (s >= 50) begin
            mant = 50'd0;
        end else begin
            rem = sig & ((50'd1 << 6'(s)) - 50'd1);
            half = 50'd1 << 6'(s - 12'sd1);
            mant = sig >> 6'(s);
            if (rem > half || (rem == half && mant[0])) begin
                mant = mant + 50'd1;
            end
        end
        e = 13'(exp) + 13'(s) + 13'sd149;
        bits = {e[10:0], 23'd0} + 34'(mant);
        if (bits >= 34'(INF)) begin
            bits = 34'(INF);
        end
        return {sign, bits[30:0]};
    endfunction

    function automatic void unpack(input f32_t a, output logic [8:0] e, output logic [23:0] m);
        if (a[30:23] == 8'd0) begin
            e = 9'd1;
            m = {1'b0, a[22:0]};
        end else begin
            e = {1'b0, a[30:23]};
            m = {1'b1, a[22:0]};
        end
    endfunction

    // First half of an add: special cases, alignment and the sum or difference of significands.
    function automatic rnd_t add_align(input f32_t a, input f32_t b);
        rnd_t r;
        logic [8:0] ea, eb, eg;
        logic [23:0] ma, mb, big, sml;
        logic sg, ss;
        logic [8:0] d;
        logic [60:0] bs, sum;
        unpack(a, ea, ma);
        unpack(b, eb, mb);
        r = '0;
        r.special = 1'b1;
        if (is_nan(a) || is_nan(b)) begin
            r.sbits = QNAN;
        end else if (is_inf(a) && is_inf(b)) begin
            r.sbits = (a[31] == b[31]) ? a : QNAN;
        end else if (is_inf(a)) begin
            r.sbits = a;
        end else if (is_inf(b)) begin
            r.sbits = b;
        end else if (is_zero(a) && is_zero(b)) begin
            r.sbits = {a[31] & b[31], 31'd0};
        end else if (is_zero(b)) begin
            r.sbits = a;
        end else if (is_zero(a)) begin
            r.sbits = b;
        end else begin
            r.special = 1'b0;
            if (ea >= eb) begin
                d = ea - eb; big = ma; sml = mb; sg = a[31]; ss = b[31]; eg = ea;
            end else begin
                d = eb - ea; big = mb; sml = ma; sg = b[31]; ss = a[31]; eg = eb;
            end
            if (d > 9'd25) begin
                d = 9'd25;
                sml = 24'd1;
            end
            bs = 61'(big) << d[4:0];
            r.exp = 11'(signed'({2'b0, eg})) - 11'sd150 - 11'(signed'({2'b0, d}));
            if (sg == ss) begin
                sum = bs + 61'(sml);
                r.sign = sg;
            end else if (bs == 61'(sml)) begin
                r.special = 1'b1;
                r.sbits = 32'd0;
                sum = 61'd0;
            end else if (bs > 61'(sml)) begin
                sum = bs - 61'(sml);
                r.sign = sg;
            end else begin
                sum = 61'(sml) - bs;
                r.sign = ss;
            end
            r.sig = sum[49:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/m4vt_row.sv
// One matrix row: four multiplies then a chain of three adds, pipelined.
// Depends on m4vt_pkg; every stage advances on the shared enable.
module m4vt_row (
    input  logic                aclk,
    input  logic                en,
    input  logic [4*32-1:0]     mrow,
    input  logic [4*32-1:0]     vec,
    output logic [31:0]         res
);
    import m4vt_pkg::*;

    // stage 1: products of significands, special results
    rnd_t        p1_reg [4];
    logic [47:0] pm_reg [4];
    // stage 2: rounded products
    f32_t        pr_reg [4];
    // adder chain: align then round per add
    rnd_t        a_reg  [3];
    f32_t        z_reg  [2];   // column 2 product, held for the second add
    f32_t        w_reg  [4];   // column 3 product, held for the third add
    f32_t        s_reg  [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                logic [31:0] a, b;
                logic [8:0] ea, eb;
                logic [23:0] ma, mb;
                rnd_t p;
                a = mrow[c*32 +: 32];
                b = vec[c*32 +: 32];
                unpack(a, ea, ma);
                unpack(b, eb, mb);
                p = '0;
                p.special = 1'b1;
                p.sign = a[31] ^ b[31];
                p.exp = 11'(signed'({2'b0, ea})) + 11'(signed'({2'b0, eb})) - 11'sd300;
                if (is_nan(a) || is_nan(b)) begin
                    p.sbits = QNAN;
                end else if (is_inf(a) || is_inf(b)) begin
                    p.sbits = (is_zero(a) || is_zero(b)) ? QNAN
                              : {a[31] ^ b[31], INF[30:0]};
                end else if (is_zero(a) || is_zero(b)) begin
                    p.sbits = {a[31] ^ b[31], 31'd0};
                end else begin
                    p.special = 1'b0;
                end
                p1_reg[c] <= p;
                pm_reg[c] <= ma * mb;
            end
            for (int c = 0; c < 4; c++) begin
                pr_reg[c] <= p1_reg[c].special ? p1_reg[c].sbits
                           : round_pack(p1_reg[c].sign, p1_reg[c].exp, 50'(pm_reg[c]));
            end
            a_reg[0] <= add_align(pr_reg[0], pr_reg[1]);
            z_reg[0] <= pr_reg[2];
            z_reg[1] <= z_reg[0];
            w_reg[0] <= pr_reg[3];
            for (int k = 1; k < 4; k++) begin
                w_reg[k] <= w_reg[k-1];
            end
            for (int k = 0; k < 3; k++) begin
                s_reg[k] <= a_reg[k].special ? a_reg[k].sbits
                          : round_pack(a_reg[k].sign, a_reg[k].exp, a_reg[k].sig);
            end
            a_reg[1] <= add_align(s_reg[0], z_reg[1]);
            a_reg[2] <= add_align(s_reg[1], w_reg[3]);
        end
    end

    assign res = s_reg[2];
endmodule

>>> rtl/matrix4_vector_transform.sv
// Top level of the 4x4 float32 matrix-vector transform.
// Depends on m4vt_pkg and m4vt_row; holds the matrix registers and valid pipe.
//
// channel  dir  handshake         payload
// s_       in   tvalid/tready     tdata = vec_x, vec_y, vec_z, vec_w
// m_       out  tvalid/tready     tdata = res_x, res_y, res_z, res_w
// cfg_     in   cfg_we            cfg_index, cfg_wdata
//
// One item per cycle when the output is not stalled; 2 multiply stages, then 3 adds of 2 stages each.
// The whole pipeline holds when the output stage is full and not taken.
// Reset clears the valid bits and the matrix to +0.0.
module matrix4_vector_transform (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [127:0]           s_tdata,  // vec_x, vec_y, vec_z, vec_w
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [127:0]           m_tdata,  // res_x, res_y, res_z, res_w
    input  logic                   cfg_we,
    input  logic [m4vt_pkg::IW-1:0] cfg_index,
    input  logic [m4vt_pkg::CW-1:0] cfg_wdata
);
    import m4vt_pkg::*;

    localparam int LAT = 8;

    logic [CW-1:0]  mat_reg [NREG];
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int i = 0; i < NREG; i++) begin
                mat_reg[i] <= '0;
            end
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_we) begin
                mat_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        m4vt_row u_row (
            .aclk (aclk),
            .en   (en),
            .mrow ({mat_reg[2*r+1], mat_reg[2*r]}),
            .vec  (s_tdata),
            .res  (m_tdata[r*32 +: 32])
        );
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready ##0 1 |=> vld_reg[0])
        else $error("accepted item lost");
`endif
endmodule

>>> sim/testbench.sv
// Self-checking testbench for matrix4_vector_transform (4x4 float32 matrix times vector).
// Depends on m4vt_pkg and the block RTL; predicts each row with bit-exact integer float math.
`timescale 1ns / 1ps

module testbench;
    import m4vt_pkg::*;

    localparam int LATENCY = 8;
    localparam longint CYCLE_LIMIT = 400000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;
    logic          cfg_we = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_wdata = '0;

    logic [31:0]   matrix [16];
    logic [127:0]  expected_vecs [$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            items_sent = 0;
    longint        cycles = 0;
    int            idle_pct = 20;

    matrix4_vector_transform u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---- float32 prediction ----
    function automatic logic [31:0] pack_round(input logic sign, input int exp,
                                               input logic [63:0] sig);
        int p, s;
        logic [63:0] mant, rem, half, bits;
        p = 62;
        while (p > 0 && !sig[p]) p--;
        s = p - 23;
        if (s < -149 - exp) s = -149 - exp;
        if (s <= 0) mant = sig << (-s);
        else if (s >= 63) mant = 0;
        else begin
            rem = sig & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            mant = sig >> s;
            if (rem > half || (rem == half && mant[0])) mant++;
        end
        bits = (64'(32'(exp + s + 149)) << 23) + mant;
        if (bits >= 64'h7F800000) bits = 64'h7F800000;
        return {sign, bits[30:0]};
    endfunction

    function automatic bit f_nan(input logic [31:0] a);
        return a[30:0] > 31'h7F800000;
    endfunction
    function automatic bit f_inf(input logic [31:0] a);
        return a[30:0] == 31'h7F800000;
    endfunction
    function automatic bit f_zero(input logic [31:0] a);
        return a[30:0] == 0;
    endfunction

    function automatic void split(input logic [31:0] a, output int e, output logic [63:0] m);
        if (a[30:23] == 0) begin
            e = 1; m = a[22:0];
        end else begin
            e = a[30:23]; m = {1'b1, a[22:0]};
        end
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic sign;
        int ea, eb;
        logic [63:0] ma, mb;
        sign = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b)) return QNAN;
        if (f_inf(a) || f_inf(b)) begin
            if (f_zero(a) || f_zero(b)) return QNAN;
            return {sign, 31'h7F800000};
        end
        if (f_zero(a) || f_zero(b)) return {sign, 31'd0};
        split(a, ea, ma);
        split(b, eb, mb);
        return pack_round(sign, ea + eb - 300, ma * mb);
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        int ea, eb, d, lsb;
        logic [63:0] ma, mb, big, sml;
        logic sg, ss;
        if (f_nan(a) || f_nan(b)) return QNAN;
        if (f_inf(a) && f_inf(b)) return (a[31] == b[31]) ? a : QNAN;
        if (f_inf(a)) return a;
        if (f_inf(b)) return b;
        if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
        if (f_zero(b)) return a;
        if (f_zero(a)) return b;
        split(a, ea, ma);
        split(b, eb, mb);
        if (ea >= eb) begin
            d = ea - eb; big = ma; sml = mb; sg = a[31]; ss = b[31]; lsb = ea - 150;
        end else begin
            d = eb - ea; big = mb; sml = ma; sg = b[31]; ss = a[31]; lsb = eb - 150;
        end
        if (d > 36) begin
            d = 36; sml = 1;
        end
        big = big << d;
        lsb -= d;
        if (sg == ss) return pack_round(sg, lsb, big + sml);
        if (big == sml) return 32'd0;
        if (big > sml) return pack_round(sg, lsb, big - sml);
        return pack_round(ss, lsb, sml - big);
    endfunction

    function automatic logic [127:0] transform_vec(input logic [127:0] v);
        logic [127:0] r;
        logic [31:0] acc;
        for (int row = 0; row < 4; row++) begin
            acc = fmul(matrix[row*4], v[31:0]);
            for (int c = 1; c < 4; c++)
                acc = fadd(acc, fmul(matrix[row*4+c], v[c*32 +: 32]));
            r[row*32 +: 32] = acc;
        end
        return r;
    endfunction

    // ---- stimulus helpers ----
    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2: f[30:0] = 31'd0;
            3: f[30:23] = 8'(3'($urandom) + 8'd124);
            4, 5, 6: f[30:23] = 8'($urandom_range(110, 140));
            default: ;
        endcase
        return f;
    endfunction

    task automatic write_reg(input int idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= IW'(idx);
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        matrix[idx*2] = val[31:0];
        matrix[idx*2+1] = val[63:32];
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_vecs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic load_matrix(input int mode);
        logic [63:0] v;
        for (int i = 0; i < NREG; i++) begin
            case (mode)
                0: v = 64'h0;
                1: v = {32'hFFFFFFFF, 32'hFFFFFFFF};
                2: v = ((i % 2) == (i / 4)) ? (((i / 2) % 2 == 1) ? 64'h3F80_0000_0000_0000
                                                                 : 64'h0000_0000_3F80_0000)
                                            : 64'h0;
                default: v = {rand_float(), rand_float()};
            endcase
            write_reg(i, v);
        end
    endtask

    task automatic send_vec(input logic [127:0] v);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        expected_vecs.push_back(transform_vec(v));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // ---- result checker ----
    always @(posedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(0, 99) >= idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_vecs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", m_tdata);
            end else begin
                logic [127:0] exp_v;
                exp_v = expected_vecs.pop_front();
                for (int f = 0; f < 4; f++)
                    if (exp_v[f*32 +: 32] !== m_tdata[f*32 +: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("res field %0d: expected %h got %h",
                                     f, exp_v[f*32 +: 32], m_tdata[f*32 +: 32]);
                    end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---- tests ----
    task automatic test_reset_matrix();
        send_vec({32'h3F800000, 32'h7F800000, 32'h7FC00001, 32'h12345678});
        send_vec({32'h80000000, 32'h00000001, 32'hFF7FFFFF, 32'h7F7FFFFF});
        wait_drained();
    endtask

    task automatic test_identity_edges();
        logic [31:0] edges [12];
        edges = '{32'h0, 32'h80000000, 32'h00000001, 32'h807FFFFF, 32'h00800000,
                  32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F800000, 32'hFF800000,
                  32'h7FC00000, 32'hFFFFFFFF, 32'h3F800000};
        load_matrix(2);
        for (int i = 0; i < 12; i++)
            send_vec({edges[(i+3)%12], edges[(i+2)%12], edges[(i+1)%12], edges[i]});
        wait_drained();
    endtask

    task automatic test_special_sums();
        write_reg(0, {32'h3F800000, 32'h3F800000});
        write_reg(1, {32'h3F800000, 32'h3F800000});
        write_reg(2, {32'h7F7FFFFF, 32'h7F7FFFFF});
        write_reg(3, {32'h0, 32'h0});
        write_reg(4, {32'h7F800000, 32'h3F800000});
        write_reg(5, {32'h0, 32'h0});
        write_reg(6, {32'h00000001, 32'h00000001});
        write_reg(7, {32'h80000000, 32'h3F000000});
        // cancellation, overflow, inf times zero, inf minus inf, underflow
        send_vec({32'h0, 32'h0, 32'hBF800000, 32'h3F800000});
        send_vec({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        send_vec({32'h3F800000, 32'h0, 32'h3F800000, 32'h3F800000});
        send_vec({32'h0, 32'h0, 32'hFF800000, 32'h7F800000});
        send_vec({32'h00000001, 32'h00000001, 32'h3F000000, 32'h3F000000});
        send_vec({32'h4B800001, 32'h33800000, 32'hCB800000, 32'h4B800000});
        wait_drained();
    endtask

    task automatic test_random_streams();
        for (int phase = 0; phase < 6; phase++) begin
            load_matrix(phase == 0 ? 1 : (phase == 5 ? 0 : 3));
            idle_pct = (phase == 2) ? 0 : 20;
            for (int i = 0; i < 215; i++)
                send_vec({rand_float(), rand_float(), rand_float(), rand_float()});
            wait_drained();
        end
        idle_pct = 20;
    endtask

    initial begin
        for (int i = 0; i < 16; i++) matrix[i] = 32'h0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_matrix();
        test_identity_edges();
        test_special_sums();
        test_random_streams();
        wait_drained();
        $display("sent %0d vectors, checked %0d results over zero, all-ones, identity,",
                 items_sent, results_seen);
        $display("special-value and random matrices with random stalls on both sides");
        if (mismatches == 0 && expected_vecs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d left over", mismatches, expected_vecs.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
